// File: rtl/core/lcsw_pkg.sv
// ----------------------------------------------------------------------------
// Load-cell weigher package
// Shared types, register codes and reset values of the stable-reading weigher.
// ----------------------------------------------------------------------------
package lcsw_pkg;

   // Default converter sample width.
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Width of the calibration and weight words.
   localparam int WORD_W = 32;

   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W = 3;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      IDX_GAIN         = 3'd0,
      IDX_OFFSET       = 3'd1,
      IDX_MIN_WEIGHT   = 3'd2,
      IDX_MAX_WEIGHT   = 3'd3,
      IDX_STABLE_COUNT = 3'd4,
      IDX_ZERO_BAND    = 3'd5
   } csr_index_type;

   // Verdict codes carried with each weight.
   typedef enum logic [1:0] {
      VERDICT_ACCEPTED     = 2'd0,
      VERDICT_OUT_OF_RANGE = 2'd1,
      VERDICT_NEAR_ZERO    = 2'd2
   } verdict_type;

   // Calibration and decision settings.
   typedef struct packed {
      logic signed [WORD_W-1:0] gain;
      logic signed [WORD_W-1:0] offset;
      logic signed [WORD_W-1:0] min_weight;
      logic signed [WORD_W-1:0] max_weight;
      logic        [7:0]        stable_count;
      logic        [WORD_W-2:0] zero_band;
   } cfg_type;

   // Reset values of the settings.
   localparam logic signed [WORD_W-1:0] GAIN_RESET       = 32'sd334291;
   localparam logic signed [WORD_W-1:0] OFFSET_RESET     = -32'sd35274;
   localparam logic signed [WORD_W-1:0] MIN_WEIGHT_RESET = 32'sd0;
   localparam logic signed [WORD_W-1:0] MAX_WEIGHT_RESET = 32'sd0;
   localparam logic        [7:0]        STABLE_RESET     = 8'd8;
   localparam logic        [WORD_W-2:0] ZERO_BAND_RESET  = 31'd26;

   // Saturation limits of the weight.
   localparam logic signed [WORD_W-1:0] WEIGHT_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

endpackage

// File: rtl/core/lcsw_csr.sv
// ----------------------------------------------------------------------------
// Weigher settings registers
// Holds the calibration and decision settings written over the config port.
// ----------------------------------------------------------------------------
module lcsw_csr
   import lcsw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            IDX_GAIN:         cfg_in.gain         = csr_wdata;
            IDX_OFFSET:       cfg_in.offset       = csr_wdata;
            IDX_MIN_WEIGHT:   cfg_in.min_weight   = csr_wdata;
            IDX_MAX_WEIGHT:   cfg_in.max_weight   = csr_wdata;
            IDX_STABLE_COUNT: cfg_in.stable_count = csr_wdata[7:0];
            IDX_ZERO_BAND:    cfg_in.zero_band    = csr_wdata[WORD_W-2:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= GAIN_RESET;
         cfg_ff.offset       <= OFFSET_RESET;
         cfg_ff.min_weight   <= MIN_WEIGHT_RESET;
         cfg_ff.max_weight   <= MAX_WEIGHT_RESET;
         cfg_ff.stable_count <= STABLE_RESET;
         cfg_ff.zero_band    <= ZERO_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/lcsw_tracker.sv
// ----------------------------------------------------------------------------
// Stability tracker
// Counts repeats of the held sample and flags the request that makes the
// reading stable; then waits for a different sample before reading again.
// ----------------------------------------------------------------------------
module lcsw_tracker
   import lcsw_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   input  logic [7:0]              stable_count,
   output logic                    emit
);

   typedef enum logic {
      PH_READING,
      PH_STALLED
   } phase_type;

   phase_type               phase_ff;
   logic [SAMPLE_WIDTH-1:0] held_ff;
   logic [7:0]              run_ff;

   logic       match;
   logic [7:0] run_inc;
   logic       hit;

   // Compare against the held sample; the run counter wraps at 256.
   assign match   = (sample == held_ff);
   assign run_inc = run_ff + 8'd1;
   assign hit     = (run_inc == stable_count);

   assign emit = accept && (phase_ff == PH_READING) && match && hit;

   // Phase, held sample and repeat count advance on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READING;
         held_ff  <= '0;
         run_ff   <= '0;
      end else if (accept) begin
         case (phase_ff)
            PH_READING: begin
               if (!match) begin
                  run_ff  <= '0;
                  held_ff <= sample;
               end else begin
                  run_ff <= run_inc;
                  if (hit) begin
                     phase_ff <= PH_STALLED;
                  end
               end
            end
            PH_STALLED: begin
               // A different sample releases the stall but is not stored.
               if (!match) begin
                  run_ff   <= '0;
                  phase_ff <= PH_READING;
               end
            end
            default: begin
               phase_ff <= PH_READING;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/lcsw_calib.sv
// ----------------------------------------------------------------------------
// Calibration stage
// Registers the stable sample, applies gain and offset with saturation,
// classifies the weight and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lcsw_calib
   import lcsw_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    push,
   input  logic [SAMPLE_WIDTH-1:0] sample,
   output logic                    take_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [WORD_W-1:0]       rsp_weight,
   output logic [1:0]              rsp_verdict
);

   localparam int PROD_W  = WORD_W + SAMPLE_WIDTH;
   localparam int SCALE_W = PROD_W - 8;
   localparam int SUM_W   = SCALE_W + 1;

   logic                    s1_valid_ff;
   logic [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic                    s1_adv;

   logic                    rsp_valid_ff;
   logic [WORD_W-1:0]       weight_ff;
   verdict_type             verdict_ff;

   logic signed [PROD_W-1:0]  prod;
   logic signed [SCALE_W-1:0] scaled;
   logic signed [SUM_W-1:0]   sum;
   logic                      in_range;
   logic signed [WORD_W-1:0]  weight;
   logic signed [WORD_W:0]    w_ext;
   logic        [WORD_W:0]    mag;
   verdict_type               verdict;

   // Stage one moves on when the result register is empty or being drained.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign take_ready = !s1_valid_ff || s1_adv;

   // Product, floor shift by eight, then intercept.
   assign prod   = $signed(s1_sample_ff) * cfg.gain;
   assign scaled = prod[PROD_W-1:8];
   assign sum    = SUM_W'(scaled) + SUM_W'(cfg.offset);

   // Saturate when the bits above the weight word are not all sign bits.
   assign in_range = (&sum[SUM_W-1:WORD_W-1]) || !(|sum[SUM_W-1:WORD_W-1]);

   always_comb begin
      if (in_range) begin
         weight = sum[WORD_W-1:0];
      end else if (sum[SUM_W-1]) begin
         weight = WEIGHT_MIN;
      end else begin
         weight = WEIGHT_MAX;
      end
   end

   // Near zero wins over the range check.
   assign w_ext = (WORD_W+1)'(weight);
   assign mag   = w_ext[WORD_W] ? unsigned'(-w_ext) : unsigned'(w_ext);

   always_comb begin
      if (mag <= {2'b00, cfg.zero_band}) begin
         verdict = VERDICT_NEAR_ZERO;
      end else if ((weight >= cfg.min_weight) && (weight <= cfg.max_weight)) begin
         verdict = VERDICT_ACCEPTED;
      end else begin
         verdict = VERDICT_OUT_OF_RANGE;
      end
   end

   // Stage one: stable sample register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= push || (s1_valid_ff && !s1_adv);
      end
      if (push) begin
         s1_sample_ff <= sample;
      end
   end

   // Result register, held while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_adv || (rsp_valid_ff && !rsp_ready);
      end
      if (s1_adv) begin
         weight_ff  <= weight;
         verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_weight  = weight_ff;
   assign rsp_verdict = verdict_ff;

endmodule

// File: rtl/core/load_cell_stable_weigher.sv
// ----------------------------------------------------------------------------
// Load-cell stable weigher
// Detects a stable load-cell reading and reports its calibrated weight with
// an accept, out-of-range or near-zero verdict.
// ----------------------------------------------------------------------------
// Usage:
// One signed converter sample is taken per request on the req_ channel. Most
// requests only update the stability tracker and produce nothing. The request
// that completes stable_count repeats of the held sample produces one result
// on the rsp_ channel: the saturated Q24.8 weight and a verdict.
// That result passes through the stable-sample register and then the
// multiply-add-compare stage that loads the result register.
// Throughput is one request per cycle; req_ready drops only while both the
// stable-sample register and the result register are full and the receiver
// stalls.
// Settings are written over the csr_ channel, one register per cycle; the user
// must write them only while the block is idle, which the block does not enforce.
// Reset restores the default calibration, clears the held sample and repeat
// count, and empties both registers.
// ----------------------------------------------------------------------------
module load_cell_stable_weigher
   import lcsw_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SAMPLE_WIDTH-1:0] req_sample,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [WORD_W-1:0]       rsp_weight,
   output logic [1:0]              rsp_verdict,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [WORD_W-1:0]       csr_wdata
);

   cfg_type cfg;
   logic    accept;
   logic    emit;
   logic    take_ready;

   // A request is taken whenever the stable-sample register can move.
   assign req_ready = take_ready;
   assign accept    = req_valid && take_ready;

   lcsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcsw_tracker #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_tracker (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .sample       (req_sample),
      .stable_count (cfg.stable_count),
      .emit         (emit)
   );

   lcsw_calib #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_calib (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .push        (emit),
      .sample      (req_sample),
      .take_ready  (take_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_weight  (rsp_weight),
      .rsp_verdict (rsp_verdict)
   );

endmodule

// File: rtl/core/lcsw_checker.sv
// ----------------------------------------------------------------------------
// Weigher port checker
// Watches the top-level ports for result timing and flow-control slips.
// ----------------------------------------------------------------------------
module lcsw_checker
   import lcsw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_weight,
   input logic [1:0]        rsp_verdict
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_weight) && $stable(rsp_verdict))
      else $error("stalled result changed");

   // No result is shown in the cycle right after a reset cycle.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   // A newly raised result must follow an accepted request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a request two cycles earlier");

   // Requests are refused only while the receiver holds off a result.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while output is free");

endmodule

bind load_cell_stable_weigher lcsw_checker u_lcsw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_weight  (rsp_weight),
   .rsp_verdict (rsp_verdict)
);

// File: verif/weigher_checker.sv
// ----------------------------------------------------------------------------
// Stable weigher checker
// Watches the request, result and settings channels of the load-cell weigher.
// It tracks the held sample and repeat count, predicts the calibrated weight
// and verdict of every stable reading, and compares each result with the
// oldest prediction.
// ----------------------------------------------------------------------------
module weigher_checker
   import lcsw_pkg::*;
#(
   parameter int SW = SAMPLE_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [SW-1:0]        req_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [WORD_W-1:0]    rsp_weight,
   input  logic [1:0]           rsp_verdict,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [WORD_W-1:0] weight;
      verdict_type       verdict;
   } reading_type;

   // Readings still owed by the block, oldest first.
   reading_type   due_readings [$];

   // Shadow copy of the settings and of the stability tracker.
   cfg_type       cfg;
   logic          stalled;
   logic [SW-1:0] held;
   logic [7:0]    run_len;

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   // Weight is the product floored by 256 plus the offset, clamped to 32 bits.
   function automatic logic [WORD_W-1:0] scaled_weight(input logic [SW-1:0] s);
      longint prod;
      longint w;
      prod = longint'($signed(cfg.gain)) * longint'($signed(s));
      w = (prod >>> 8) + longint'($signed(cfg.offset));
      if (w > longint'(WEIGHT_MAX)) begin
         w = longint'(WEIGHT_MAX);
      end else if (w < longint'(WEIGHT_MIN)) begin
         w = longint'(WEIGHT_MIN);
      end
      return w[WORD_W-1:0];
   endfunction

   // The near-zero test wins over the range test.
   function automatic verdict_type weight_verdict(input logic [WORD_W-1:0] w);
      longint v;
      longint mag;
      v = longint'($signed(w));
      mag = (v < 0) ? -v : v;
      if (mag <= longint'(cfg.zero_band)) begin
         return VERDICT_NEAR_ZERO;
      end
      if (longint'($signed(cfg.min_weight)) <= v && v <= longint'($signed(cfg.max_weight))) begin
         return VERDICT_ACCEPTED;
      end
      return VERDICT_OUT_OF_RANGE;
   endfunction

   task automatic apply_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
      case (idx)
         IDX_GAIN: begin
            cfg.gain = d;
         end
         IDX_OFFSET: begin
            cfg.offset = d;
         end
         IDX_MIN_WEIGHT: begin
            cfg.min_weight = d;
         end
         IDX_MAX_WEIGHT: begin
            cfg.max_weight = d;
         end
         IDX_STABLE_COUNT: begin
            cfg.stable_count = d[7:0];
         end
         IDX_ZERO_BAND: begin
            cfg.zero_band = d[WORD_W-2:0];
         end
         default: begin
         end
      endcase
   endtask

   // One accepted sample moves the tracker; a completed run owes one reading.
   task automatic track_sample(input logic [SW-1:0] s);
      reading_type r;
      if (stalled) begin
         // A different sample releases the stall but is not kept.
         if (s != held) begin
            run_len = '0;
            stalled = 1'b0;
         end
      end else if (s != held) begin
         run_len = '0;
         held = s;
      end else begin
         // The count wraps, so a stable count of zero takes 256 repeats.
         run_len = run_len + 8'd1;
         if (run_len == cfg.stable_count) begin
            stalled = 1'b1;
            r.weight = scaled_weight(held);
            r.verdict = weight_verdict(r.weight);
            due_readings.push_back(r);
         end
      end
   endtask

   // Results are checked before the request of the same edge is tracked.
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         cfg.gain = GAIN_RESET;
         cfg.offset = OFFSET_RESET;
         cfg.min_weight = MIN_WEIGHT_RESET;
         cfg.max_weight = MAX_WEIGHT_RESET;
         cfg.stable_count = STABLE_RESET;
         cfg.zero_band = ZERO_BAND_RESET;
         stalled = 1'b0;
         held = '0;
         run_len = '0;
         due_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_readings.size() == 0) begin
               report_mismatch("result with none expected, weight", rsp_weight, '0);
            end else begin
               want = due_readings.pop_front();
               if (rsp_weight !== want.weight) begin
                  report_mismatch("weight", rsp_weight, want.weight);
               end
               if (rsp_verdict !== want.verdict) begin
                  report_mismatch("verdict", WORD_W'(rsp_verdict), WORD_W'(want.verdict));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            track_sample(req_sample);
         end
      end
      pending <= due_readings.size();
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Stable weigher testbench
// Drives sample requests and settings into the load-cell weigher with random
// stalls on both channels. A short directed opening covers the sample extremes
// and the stall release rules; then a series of settings, the extremes among
// them, each runs mostly well-formed runs of equal samples with random values.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcsw_pkg::*;

   localparam int SW           = SAMPLE_WIDTH_DEF;
   localparam int LONG_HOLD    = 40;
   localparam int SETTLE       = 6;
   localparam int IDLE_LIMIT   = 1000;
   localparam int NUM_SETTINGS = 9;

   // Indexes beyond the register map; writes to them are ignored.
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SW-1:0]        req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_W-1:0]    rsp_weight;
   logic [1:0]           rsp_verdict;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = IDX_GAIN;
   logic [WORD_W-1:0]    csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   int   long_holds_asked = 0;
   int   long_holds_given = 0;
   logic quiet_tail = 1'b0;

   // Opening requests, run with a stable count of one and reset calibration.
   logic [SW-1:0] opening_samples [0:22] = '{
      16'h0000, 16'h0000,
      16'h7fff, 16'h7fff, 16'h7fff,
      16'h8000, 16'h8000, 16'h8000,
      16'hffff, 16'hffff, 16'hffff,
      16'h001b, 16'h001b, 16'h001b,
      16'h0005, 16'h0006, 16'h0006,
      16'h5555, 16'h5555, 16'h5555,
      16'haaaa, 16'haaaa, 16'haaaa
   };

   always #1 clock = ~clock;

   load_cell_stable_weigher #(
      .SAMPLE_WIDTH(SW)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_weight  (rsp_weight),
      .rsp_verdict (rsp_verdict),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   weigher_checker #(
      .SW(SW)
   ) watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_weight  (rsp_weight),
      .rsp_verdict (rsp_verdict),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("load_cell_stable_weigher verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random ready bursts, plus a long hold-off when asked.
   initial begin : rsp_side
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (long_holds_asked != long_holds_given) begin
            long_holds_given++;
            rsp_ready <= 1'b0;
            hold = LONG_HOLD;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            hold = $urandom_range(1, 5);
         end else begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 12);
         end
         repeat (hold) @(posedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // One sample request, sometimes after a short idle burst.
   task automatic send_sample(input logic [SW-1:0] s);
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Wait until every owed reading is out, then let the pipeline settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [SW-1:0] pick_sample();
      int r;
      case ($urandom_range(0, 7))
         0: r = 0;
         1: r = 32'h7fff;
         2: r = 32'h8000;
         3: r = int'($urandom_range(0, 80)) - 40;
         default: r = int'($urandom);
      endcase
      return r[SW-1:0];
   endfunction

   // Writes one full setting; returns the repeats needed for a stable reading.
   task automatic program_setting(input int p, output int stable_eff);
      int gain;
      int offset;
      int lo;
      int hi;
      int swap;
      int band;
      logic [WORD_W-1:0] count_word;
      count_word = $urandom;
      case (p)
         0: begin
            // Positive saturation, widest range, empty band, fastest reading.
            gain = 32'h7fffffff;
            offset = 32'h7fffffff;
            lo = 32'h80000000;
            hi = 32'h7fffffff;
            band = 0;
            count_word[7:0] = 8'd1;
         end
         1: begin
            // Negative saturation, inverted range, widest band, largest nonzero count.
            gain = 32'h80000000;
            offset = 32'h80000000;
            lo = 0;
            hi = -1;
            band = 32'hffffffff;
            count_word[7:0] = 8'd255;
         end
         2: begin
            // A stable count of zero wraps to 256 repeats.
            gain = $urandom;
            offset = $urandom_range(0, 4095);
            lo = -(1 << 30);
            hi = 1 << 30;
            band = $urandom_range(0, 4095);
            count_word[7:0] = 8'd0;
         end
         default: begin
            gain = ($urandom_range(0, 1) == 0) ? int'($urandom)
                                               : int'($urandom_range(0, 2097152)) - 1048576;
            offset = ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                 : int'($urandom_range(0, 2097152)) - 1048576;
            lo = $urandom;
            hi = $urandom;
            if ($urandom_range(0, 3) != 0 && lo > hi) begin
               swap = lo;
               lo = hi;
               hi = swap;
            end
            band = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 65535));
            count_word[7:0] = 8'($urandom_range(1, 6));
         end
      endcase
      write_reg(IDX_GAIN, gain);
      write_reg(IDX_OFFSET, offset);
      write_reg(IDX_MIN_WEIGHT, lo);
      write_reg(IDX_MAX_WEIGHT, hi);
      write_reg(IDX_STABLE_COUNT, count_word);
      write_reg(IDX_ZERO_BAND, band);
      if (p == 2) begin
         write_reg(IDX_SPARE_LO, $urandom);
         write_reg(IDX_SPARE_HI, $urandom);
      end
      csr_valid <= 1'b0;
      stable_eff = (count_word[7:0] == 8'd0) ? 256 : int'(count_word[7:0]);
   endtask

   // Mostly runs long enough to become stable, some cut short, some lone samples.
   task automatic run_random(input int budget, input int stable_eff);
      int sent;
      int kind;
      int len;
      logic [SW-1:0] v;
      sent = 0;
      while (sent < budget) begin
         kind = $urandom_range(0, 19);
         v = pick_sample();
         if (kind < 14 || stable_eff > 8) begin
            len = stable_eff + 1 + $urandom_range(0, 2);
         end else if (kind < 17) begin
            len = $urandom_range(1, stable_eff);
         end else begin
            len = 1;
         end
         repeat (len) send_sample(v);
         sent += len;
      end
   endtask

   initial begin : stimulus
      int p;
      int stable_eff;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening with reset calibration and a stable count of one.
      write_reg(IDX_STABLE_COUNT, 32'd1);
      csr_valid <= 1'b0;
      foreach (opening_samples[i]) begin
         send_sample(opening_samples[i]);
      end
      drain();

      // Random runs under each setting; the block is drained between them.
      for (p = 0; p < NUM_SETTINGS; p++) begin
         program_setting(p, stable_eff);
         if (p == 0) begin
            long_holds_asked <= long_holds_asked + 1;
         end
         if (p == NUM_SETTINGS - 1) begin
            quiet_tail <= 1'b1;
         end
         run_random((stable_eff > 8) ? 1 : ((p == 0) ? 170 : 150), stable_eff);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("load_cell_stable_weigher verification clean");
      end else begin
         $display("load_cell_stable_weigher verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lcsw_pkg.sv
rtl/core/lcsw_csr.sv
rtl/core/lcsw_tracker.sv
rtl/core/lcsw_calib.sv
rtl/core/load_cell_stable_weigher.sv
rtl/core/lcsw_checker.sv
verif/weigher_checker.sv
verif/tb.sv
